/* src/http_response_body_framer_unit_macros.svh */
// Assertion macros for the body framer.
`ifndef HTTP_RESPONSE_BODY_FRAMER_UNIT_MACROS_SVH
`define HTTP_RESPONSE_BODY_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HTTPBF_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("body framer check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HTTPBF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("body framer check failed");

`endif

/* src/httpbf_pkg.sv */
package httpbf_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  body_byte;
        logic        last_body;
        logic [31:0] bytes_passed;
    } result_t;

    localparam logic [3:0] KEY_LEN    = 4'd14;
    localparam logic [1:0] SKIP_COUNT = 2'd2;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    // Characters of "Content-Length"
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                4'd0:    c = 8'h43;  // C
                4'd1:    c = 8'h6F;  // o
                4'd2:    c = 8'h6E;  // n
                4'd3:    c = 8'h74;  // t
                4'd4:    c = 8'h65;  // e
                4'd5:    c = 8'h6E;  // n
                4'd6:    c = 8'h74;  // t
                4'd7:    c = 8'h2D;  // -
                4'd8:    c = 8'h4C;  // L
                4'd9:    c = 8'h65;  // e
                4'd10:   c = 8'h6E;  // n
                4'd11:   c = 8'h67;  // g
                4'd12:   c = 8'h74;  // t
                4'd13:   c = 8'h68;  // h
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

/* src/httpbf_core.sv */
module httpbf_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          data_byte,
    output httpbf_pkg::result_t result
);
    import httpbf_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_BODY   = 4'b0010,
        PH_DONE   = 4'b0100,
        PH_ERROR  = 4'b1000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             match_pos_reg, match_pos_next;
    logic [1:0]             skip_left_reg, skip_left_next;
    logic                   in_digits_reg, in_digits_next;
    logic [1:0]             line_len_reg, line_len_next;
    logic [LENGTH_BITS-1:0] content_length_reg, content_length_next;
    logic [LENGTH_BITS-1:0] body_count_reg, body_count_next;

    logic [LENGTH_BITS+3:0]  acc_wide;
    logic [LENGTH_BITS+31:0] count_ext;
    logic [3:0]              key_pos;
    logic [3:0]              key_pos_next;

    // Length times ten plus the digit, with four guard bits for saturation
    assign acc_wide = ({4'b0, content_length_reg} << 3) + ({4'b0, content_length_reg} << 1)
                    + {{LENGTH_BITS{1'b0}}, data_byte[3:0]};
    assign count_ext = {32'b0, body_count_next};

    always_comb
    begin
        phase_next          = phase_reg;
        match_pos_next      = match_pos_reg;
        skip_left_next      = skip_left_reg;
        in_digits_next      = in_digits_reg;
        line_len_next       = line_len_reg;
        content_length_next = content_length_reg;
        body_count_next     = body_count_reg;
        key_pos             = '0;
        key_pos_next        = '0;
        result              = '0;
        result.result_kind  = KIND_HEADER;

        case (phase_reg)
            PH_HEADER:
            begin
                if (data_byte == CHAR_NL)
                begin
                    skip_left_next = '0;
                    in_digits_next = 1'b0;
                    match_pos_next = '0;
                end
                else if (skip_left_reg != 2'd0)
                begin
                    skip_left_next = skip_left_reg - 2'd1;
                    if (skip_left_reg == 2'd1)
                    begin
                        in_digits_next = 1'b1;
                    end
                end
                else if (in_digits_reg)
                begin
                    if (data_byte inside {[CHAR_0:CHAR_9]})
                    begin
                        if (acc_wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                        begin
                            content_length_next = '1;
                        end
                        else
                        begin
                            content_length_next = acc_wide[LENGTH_BITS-1:0];
                        end
                    end
                    else
                    begin
                        in_digits_next = 1'b0;
                    end
                end
                else if (content_length_reg == '0)
                begin
                    key_pos = (match_pos_reg < KEY_LEN) ? match_pos_reg : 4'd0;
                    if (data_byte == key_char(key_pos))
                    begin
                        key_pos_next = key_pos + 4'd1;
                    end
                    else
                    begin
                        // restart, counting this byte if it opens the key
                        key_pos_next = (data_byte == key_char(4'd0)) ? 4'd1 : 4'd0;
                    end
                    if (key_pos_next >= KEY_LEN)
                    begin
                        match_pos_next = '0;
                        skip_left_next = SKIP_COUNT;
                    end
                    else
                    begin
                        match_pos_next = key_pos_next;
                    end
                end

                // a one-byte line ends the header
                if (data_byte == CHAR_NL)
                begin
                    if (line_len_reg == 2'd1)
                    begin
                        phase_next = (content_length_reg == '0) ? PH_ERROR : PH_BODY;
                    end
                    line_len_next = '0;
                end
                else if (line_len_reg != 2'd3)
                begin
                    line_len_next = line_len_reg + 2'd1;
                end

                result.result_kind = (phase_next == PH_ERROR) ? KIND_ERROR : KIND_HEADER;
            end
            PH_BODY:
            begin
                body_count_next     = body_count_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                result.result_kind  = KIND_BODY;
                result.body_byte    = data_byte;
                result.bytes_passed = count_ext[31:0];
                if (body_count_next >= content_length_reg)
                begin
                    result.last_body = 1'b1;
                    phase_next       = PH_DONE;
                end
            end
            PH_DONE:
            begin
                result.result_kind  = KIND_DONE;
                result.bytes_passed = count_ext[31:0];
            end
            default:
            begin
                result.result_kind = KIND_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            match_pos_reg      <= '0;
            skip_left_reg      <= '0;
            in_digits_reg      <= 1'b0;
            line_len_reg       <= '0;
            content_length_reg <= '0;
            body_count_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg          <= phase_next;
            match_pos_reg      <= match_pos_next;
            skip_left_reg      <= skip_left_next;
            in_digits_reg      <= in_digits_next;
            line_len_reg       <= line_len_next;
            content_length_reg <= content_length_next;
            body_count_reg     <= body_count_next;
        end
    end

endmodule

/* src/httpbf_skid.sv */
module httpbf_skid #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             out_free;
    logic             in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_fire)
        begin
            // hold the item while the output stalls
            skid_data_reg <= in_data;
        end
    end

endmodule

/* src/http_response_body_framer_unit.sv */
// Channel   Dir  tdata (low bit up)                 tuser          tlast
// s_axis    in   data_byte[7:0]                     -              -
// m_axis    out  body_byte[7:0], bytes_passed[39:8] result_kind    last_body
//
// One result item per input item; an item can enter every cycle while s_axis_tready is high.
// When the output is free, m_axis_tvalid rises in the cycle after the input accept.
// An output register plus one skid entry hold up to two items; an item is still
// accepted in a cycle of m_axis stall, and tready falls only while both entries hold items.
// rst_n clears the header parser, the length and the body count asynchronously.
`include "http_response_body_framer_unit_macros.svh"

module http_response_body_framer_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // body_byte[7:0], bytes_passed[39:8]
    output logic [1:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last_body
);
    import httpbf_pkg::*;

    localparam int RES_W = $bits(result_t);

    logic             in_fire;
    result_t          step_result;
    result_t          out_result;
    logic [RES_W-1:0] out_bits;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    httpbf_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (in_fire),
        .data_byte(s_axis_tdata),
        .result   (step_result)
    );

    httpbf_skid #(
        .WIDTH(RES_W)
    ) u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (step_result),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (out_bits)
    );

    assign out_result   = result_t'(out_bits);
    assign m_axis_tdata = {out_result.bytes_passed, out_result.body_byte};
    assign m_axis_tuser = out_result.result_kind;
    assign m_axis_tlast = out_result.last_body;

    `HTTPBF_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid)
    `HTTPBF_ASSERT_NEXT(a_accept_reaches_out, in_fire, m_axis_tvalid)
    `HTTPBF_ASSERT_IMPL(a_last_is_body, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_BODY)

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import httpbf_pkg::*;

    localparam int LEN_W        = 32;
    localparam int STREAM_ITEMS = 950;
    localparam int HOLD_AT_ITEM = 300;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 500000;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DONE,
        PH_ERROR
    } phase_t;

    string key_text = "Content-Length";

    // Mirrors the framer state and queues the result each accepted byte must produce.
    class framer_scoreboard;
        phase_t           phase          = PH_HEADER;
        logic [3:0]       match_pos      = '0;
        logic [1:0]       skip_left      = '0;
        logic             in_digits      = 1'b0;
        logic [1:0]       line_len       = '0;
        logic [LEN_W-1:0] content_length = '0;
        logic [LEN_W-1:0] body_count     = '0;
        result_t          pending[$];
        int               n_out          = 0;
        int               errors         = 0;

        function void note_input(logic [7:0] b);
            result_t         r;
            longint unsigned len_max;
            longint unsigned digit;
            int              p;
            r = '0;
            len_max = (64'd1 << LEN_W) - 1;
            case (phase)
                PH_HEADER:
                begin
                    if (b == CHAR_NL)
                    begin
                        skip_left = '0;
                        in_digits = 1'b0;
                        match_pos = '0;
                    end
                    else if (skip_left != 0)
                    begin
                        skip_left = skip_left - 2'd1;
                        if (skip_left == 0)
                            in_digits = 1'b1;
                    end
                    else if (in_digits)
                    begin
                        if (b >= CHAR_0 && b <= CHAR_9)
                        begin
                            digit = 64'(b - CHAR_0);
                            // saturate instead of wrapping
                            if (content_length > (len_max - digit) / 10)
                                content_length = LEN_W'(len_max);
                            else
                                content_length = LEN_W'(content_length * 10 + digit);
                        end
                        else
                            in_digits = 1'b0;
                    end
                    else if (content_length == 0)
                    begin
                        p = (match_pos < KEY_LEN) ? match_pos : 0;
                        if (b == key_text[p])
                            p++;
                        else
                            p = (b == key_text[0]) ? 1 : 0;
                        if (p >= KEY_LEN)
                        begin
                            match_pos = '0;
                            skip_left = SKIP_COUNT;
                        end
                        else
                            match_pos = 4'(p);
                    end

                    if (b == CHAR_NL)
                    begin
                        if (line_len == 1)
                            phase = (content_length == 0) ? PH_ERROR : PH_BODY;
                        line_len = '0;
                    end
                    else if (line_len < 3)
                        line_len = line_len + 2'd1;

                    r.result_kind = (phase == PH_ERROR) ? KIND_ERROR : KIND_HEADER;
                end
                PH_BODY:
                begin
                    body_count     = body_count + 1'b1;
                    r.result_kind  = KIND_BODY;
                    r.body_byte    = b;
                    r.bytes_passed = 32'(body_count);
                    if (body_count >= content_length)
                    begin
                        r.last_body = 1'b1;
                        phase       = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    r.result_kind  = KIND_DONE;
                    r.bytes_passed = 32'(body_count);
                end
                default:
                    r.result_kind = KIND_ERROR;
            endcase
            pending.push_back(r);
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 200)
                $display("ERROR: %s", msg);
        endtask

        task check_result(input result_t got);
            result_t want;
            n_out++;
            if (pending.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", n_out));
                return;
            end
            want = pending.pop_front();
            if (got.result_kind !== want.result_kind)
                report($sformatf("result %0d: result_kind %0d, expected %0d",
                                 n_out, got.result_kind, want.result_kind));
            if (got.body_byte !== want.body_byte)
                report($sformatf("result %0d: body_byte %0h, expected %0h",
                                 n_out, got.body_byte, want.body_byte));
            if (got.last_body !== want.last_body)
                report($sformatf("result %0d: last_body %0b, expected %0b",
                                 n_out, got.last_body, want.last_body));
            if (got.bytes_passed !== want.bytes_passed)
                report($sformatf("result %0d: bytes_passed %0d, expected %0d",
                                 n_out, got.bytes_passed, want.bytes_passed));
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    framer_scoreboard sb = new();
    logic [7:0]       stream[$];
    int               cycle_count = 0;
    bit               hold_req    = 1'b0;
    bit               hold_done   = 1'b0;

    http_response_body_framer_unit #(
        .LENGTH_BITS(LEN_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, and whole stretches with none.
    function automatic int pick_gap();
        int r;
        if ((cycle_count / 300) % 4 == 2)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic [7:0] any_but_nl();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == CHAR_NL);
        return v;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            stream.push_back(s[i]);
    endfunction

    // Header line of two or more bytes: partial keys, stray C's and random bytes.
    function automatic void add_noise_line();
        int n;
        int k;
        int start;
        start = stream.size();
        n = $urandom_range(2, 24);
        while (stream.size() - start < n)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    k = $urandom_range(1, KEY_LEN - 1);
                    add_text(key_text.substr(0, k - 1));
                end
                1:
                    stream.push_back(key_text[0]);
                default:
                    stream.push_back(any_but_nl());
            endcase
        end
        stream.push_back(CHAR_NL);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        // keep offering back to back while the receiver holds off
        gap = (hold_req && !hold_done) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(negedge clk);
        while (s_axis_tready !== 1'b1)
            @(negedge clk);
        sb.note_input(b);
        @(posedge clk);
    endtask

    initial
    begin : receiver
        int stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Outputs are stable between edges: what holds at the falling edge is what
    // the next rising edge accepts.
    always @(negedge clk)
    begin : result_monitor
        result_t seen;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            seen.result_kind  = kind_t'(m_axis_tuser);
            seen.body_byte    = m_axis_tdata[7:0];
            seen.last_body    = m_axis_tlast;
            seen.bytes_passed = m_axis_tdata[39:8];
            sb.check_result(seen);
        end
    end

    initial
    begin : main_flow
        int scenario;
        int body_len;
        scenario = $urandom_range(0, 9);

        add_text("HTTP/1.1 200 OK\r\n");
        add_text("CContent-Lengt\n");
        add_text("Content-Length\n");
        add_text("Content-Length:\n");
        add_text("Content-Length: x\r\n");
        add_text("Content-Length: 0\r\n");
        add_text("\n");
        repeat ($urandom_range(3, 12)) add_noise_line();

        if (scenario == 1)
        begin
            // one past the largest length, then more digits: saturates
            add_text({key_text, ": 4294967296"});
            repeat ($urandom_range(0, 8)) stream.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
            add_text("\r\n");
        end
        else if (scenario != 0)
        begin
            body_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 600);
            add_text(key_text);
            if ($urandom_range(0, 3) == 0)
            begin
                stream.push_back(any_but_nl());
                stream.push_back(any_but_nl());
            end
            else
                add_text(": ");
            repeat ($urandom_range(0, 2)) stream.push_back(CHAR_0);
            add_text($sformatf("%0d", body_len));
            if ($urandom_range(0, 1))
                add_text(";q=1");
            add_text("\r\n");
        end

        // ignored once a length is known
        if (scenario != 0)
            add_text({key_text, ": 77\r\n"});
        repeat ($urandom_range(1, 6)) add_noise_line();

        // one-byte line closes the header
        stream.push_back(any_but_nl());
        stream.push_back(CHAR_NL);
        stream.push_back(8'hFF);
        stream.push_back(8'h00);
        while (stream.size() < STREAM_ITEMS)
            stream.push_back(8'($urandom_range(0, 255)));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < stream.size(); i++)
        begin
            if (i == HOLD_AT_ITEM)
                hold_req = 1'b1;
            send_byte(stream[i]);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
